### rtl/sftf_pkg.sv
package sftf_pkg;

	localparam int PATTERN_BYTES = 8;
	localparam int IDX_W         = $clog2(PATTERN_BYTES);
	localparam int LEN_W         = 4;
	localparam int PAT_W         = 8 * PATTERN_BYTES;
	localparam int APB_DATA_W    = 64;
	localparam int APB_ADDR_W    = 6;
	localparam int REG_SEL_W     = 3;

	typedef enum logic [1:0] {
		REQ_START   = 2'd0,
		REQ_BYTE    = 2'd1,
		REQ_TIMEOUT = 2'd2,
		REQ_UNUSED  = 2'd3
	} req_code_t;

	typedef enum logic [2:0] {
		ST_IDLE       = 3'd0,
		ST_SEARCHING  = 3'd1,
		ST_TARGET     = 3'd2,
		ST_TERMINATOR = 3'd3,
		ST_TIMED_OUT  = 3'd4
	} status_code_t;

	typedef enum logic [REG_SEL_W-1:0] {
		REG_TARGET_PATTERN = 3'd0,
		REG_TARGET_LENGTH  = 3'd1,
		REG_TERM_PATTERN   = 3'd2,
		REG_TERM_LENGTH    = 3'd3,
		REG_TERM_ENABLED   = 3'd4
	} reg_sel_t;

	typedef struct packed {
		logic [PAT_W-1:0] target_pattern;
		logic [LEN_W-1:0] target_length;
		logic [PAT_W-1:0] terminator_pattern;
		logic [LEN_W-1:0] terminator_length;
		logic             terminator_enabled;
	} cfg_t;

	typedef struct packed {
		logic [IDX_W-1:0] target_idx;
		logic [IDX_W-1:0] term_idx;
		logic             active;
	} search_state_t;

	// clamp a length register to the pattern size
	function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] len);
		logic [LEN_W-1:0] lim;
		lim = LEN_W'(PATTERN_BYTES);
		return (len > lim) ? lim : len;
	endfunction

	// index modulo the pattern length; parallel compares against the multiples
	// of the length, the largest multiple not above the index wins
	function automatic logic [IDX_W-1:0] wrap_index(input logic [IDX_W-1:0] cur,
	                                                input logic [LEN_W-1:0] len);
		logic [IDX_W-1:0] res;
		logic [7:0]       prod;
		res = cur;
		for (int q = 1; q < PATTERN_BYTES; q++) begin
			prod = 8'(q) * 8'(len);
			if (len != '0 && 8'(cur) >= prod) begin
				res = cur - IDX_W'(prod);
			end
		end
		return res;
	endfunction

	function automatic logic [7:0] pat_byte(input logic [PAT_W-1:0] pat,
	                                        input logic [IDX_W-1:0] idx);
		return pat[{idx, 3'b000} +: 8];
	endfunction

	// longest suffix of (matched prefix + c) that is also a pattern prefix
	function automatic logic [LEN_W-1:0] next_index(input logic [PAT_W-1:0] pat,
	                                                input logic [IDX_W-1:0] cur,
	                                                input logic [7:0]       c);
		logic [LEN_W-1:0] res;
		logic             ok;
		logic [IDX_W-1:0] src;
		res = '0;
		for (int j = 0; j < PATTERN_BYTES; j++) begin
			if (IDX_W'(j) <= cur) begin
				ok = (pat_byte(pat, IDX_W'(j)) == c);
				for (int i = 0; i < PATTERN_BYTES - 1; i++) begin
					if (i < j) begin
						src = IDX_W'(i) + cur - IDX_W'(j);
						ok  = ok & (pat_byte(pat, IDX_W'(i)) == pat_byte(pat, src));
					end
				end
				if (ok) begin
					res = LEN_W'(j + 1);
				end
			end
		end
		return res;
	endfunction

endpackage

### rtl/sftf_if.sv
interface sftf_req_if import sftf_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [1:0]      req_type;
	logic [7:0]      data_byte;

	modport source (output valid, output req_type, output data_byte, input ready);
	modport sink   (input valid, input req_type, input data_byte, output ready);
endinterface

interface sftf_rsp_if import sftf_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [2:0]      status;

	modport source (output valid, output status, input ready);
	modport sink   (input valid, input status, output ready);
endinterface

### rtl/sftf_step.sv
module sftf_step import sftf_pkg::*; (
	input  cfg_t          cfg,
	input  search_state_t cur,
	input  logic [1:0]    req_type,
	input  logic [7:0]    data_byte,
	output search_state_t nxt,
	output logic [2:0]    status
);

	logic [LEN_W-1:0] tlen;
	logic [LEN_W-1:0] mlen;
	logic [IDX_W-1:0] t_cur;
	logic [IDX_W-1:0] m_cur;
	logic [LEN_W-1:0] t_adv;
	logic [LEN_W-1:0] m_adv;
	search_state_t    done_st;

	assign tlen  = eff_len(cfg.target_length);
	assign mlen  = eff_len(cfg.terminator_length);
	// a length rewritten mid-search folds the held index back into range
	assign t_cur = wrap_index(cur.target_idx, tlen);
	assign m_cur = wrap_index(cur.term_idx, mlen);
	assign t_adv = next_index(cfg.target_pattern, t_cur, data_byte);
	assign m_adv = next_index(cfg.terminator_pattern, m_cur, data_byte);
	assign done_st = '{target_idx: '0, term_idx: '0, active: 1'b0};

	always_comb begin
		nxt    = cur;
		status = ST_IDLE;
		case (req_code_t'(req_type))
			REQ_START: begin
				if (tlen == '0) begin
					nxt    = done_st;
					status = ST_TARGET;
				end else if (cfg.terminator_enabled && mlen == '0) begin
					nxt    = done_st;
					status = ST_TERMINATOR;
				end else begin
					nxt    = '{target_idx: '0, term_idx: '0, active: 1'b1};
					status = ST_SEARCHING;
				end
			end
			REQ_BYTE: begin
				if (cur.active) begin
					if (t_adv >= tlen) begin
						nxt    = done_st;
						status = ST_TARGET;
					end else if (cfg.terminator_enabled) begin
						if (m_adv >= mlen) begin
							nxt    = done_st;
							status = ST_TERMINATOR;
						end else begin
							nxt.target_idx = t_adv[IDX_W-1:0];
							nxt.term_idx   = m_adv[IDX_W-1:0];
							status         = ST_SEARCHING;
						end
					end else begin
						nxt.target_idx = t_adv[IDX_W-1:0];
						status         = ST_SEARCHING;
					end
				end
			end
			REQ_TIMEOUT: begin
				if (cur.active) begin
					nxt    = done_st;
					status = ST_TIMED_OUT;
				end
			end
			default: begin
				status = cur.active ? ST_SEARCHING : ST_IDLE;
			end
		endcase
	end

endmodule

### rtl/stream_target_or_terminator_finder_top.sv
// stream target / terminator finder
//
// req channel: one request per accepted handshake; req_type selects start,
// stream byte or timeout, data_byte carries the byte
// rsp channel: exactly one status per request, in request order
// config: apb-style port, 64-bit data, register i at byte address 8*i,
// written in the access phase; pready is tied high, reads return the register
//
// path: a request is captured in the input stage, evaluated there against
// the match indices, and its status moves into the output register, raising
// rsp.valid, as soon as that register is free or drains
// throughput: one request per cycle while rsp is not held off; the fallback
// compare for both patterns is a single layer of parallel byte comparators
// in the input stage
//
// reset: config, valid flags and search state clear, both indices zero, search idle
// stall: while rsp is held off the output register keeps its status, the
// input stage holds one more request, and then req.ready drops
module stream_target_or_terminator_finder_top import sftf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	sftf_req_if.sink              req,
	sftf_rsp_if.source            rsp,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	cfg_t          cfg_q;
	logic          cfg_wr;
	reg_sel_t      reg_sel;

	// input stage
	logic          valid_s1;
	logic [1:0]    req_type_s1;
	logic [7:0]    data_byte_s1;
	logic          adv_s1;

	// search state and output register
	search_state_t state_q;
	search_state_t state_nxt;
	logic [2:0]    status_nxt;
	logic          out_valid_q;
	logic [2:0]    status_q;

	// config port
	assign pready  = 1'b1;
	assign reg_sel = reg_sel_t'(paddr[APB_ADDR_W-1 -: REG_SEL_W]);
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_TARGET_PATTERN: cfg_q.target_pattern     <= pwdata[PAT_W-1:0];
				REG_TARGET_LENGTH:  cfg_q.target_length      <= pwdata[LEN_W-1:0];
				REG_TERM_PATTERN:   cfg_q.terminator_pattern <= pwdata[PAT_W-1:0];
				REG_TERM_LENGTH:    cfg_q.terminator_length  <= pwdata[LEN_W-1:0];
				REG_TERM_ENABLED:   cfg_q.terminator_enabled <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (reg_sel)
			REG_TARGET_PATTERN: prdata = APB_DATA_W'(cfg_q.target_pattern);
			REG_TARGET_LENGTH:  prdata = APB_DATA_W'(cfg_q.target_length);
			REG_TERM_PATTERN:   prdata = APB_DATA_W'(cfg_q.terminator_pattern);
			REG_TERM_LENGTH:    prdata = APB_DATA_W'(cfg_q.terminator_length);
			REG_TERM_ENABLED:   prdata = APB_DATA_W'(cfg_q.terminator_enabled);
			default:            prdata = '0;
		endcase
	end

	// the input stage moves on whenever the output register is free or drains
	assign adv_s1    = ~out_valid_q | rsp.ready;
	assign req.ready = ~valid_s1 | adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			req_type_s1  <= req.req_type;
			data_byte_s1 <= req.data_byte;
		end
	end

	// match step: both index updates and the status for one request
	sftf_step u_step (
		.cfg       (cfg_q),
		.cur       (state_q),
		.req_type  (req_type_s1),
		.data_byte (data_byte_s1),
		.nxt       (state_nxt),
		.status    (status_nxt)
	);

	// state commits together with the status leaving the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (valid_s1 && adv_s1) begin
				state_q <= state_nxt;
			end
			if (adv_s1) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv_s1) begin
			status_q <= status_nxt;
		end
	end

	assign rsp.valid  = out_valid_q;
	assign rsp.status = status_q;

endmodule
